@@ rtl/core/digit_mask_crossfade_renderer_defines.svh @@
// Assertion macros for the digit mask crossfade renderer
`ifndef DIGIT_MASK_CROSSFADE_RENDERER_DEFINES_SVH
`define DIGIT_MASK_CROSSFADE_RENDERER_DEFINES_SVH

// same-cycle implication
`define DMCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DMCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dmcr_pkg.sv @@
// Package: shared constants and the digit-to-LED assignment
`timescale 1ns / 1ps
package dmcr_pkg;
  localparam int DIGIT_LEDS = 22;
  localparam logic [16:0] Q_ONE = 17'd65536;
  localparam logic [20:0] STEP_DIVIDEND = 21'd1310720;

  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_PUSH   = 3'd1;
  localparam logic [2:0] REQ_COMMIT = 3'd2;
  localparam logic [2:0] REQ_TICK   = 3'd3;
  localparam logic [2:0] REQ_RENDER = 3'd4;

  localparam logic [2:0] REG_DIGITS     = 3'd0;
  localparam logic [2:0] REG_INSTANT    = 3'd1;
  localparam logic [2:0] REG_FADE_TIME  = 3'd2;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd3;
  localparam logic [2:0] REG_ON_COLOR   = 3'd4;
  localparam logic [2:0] REG_OFF_COLOR  = 3'd5;

  typedef logic [DIGIT_LEDS-1:0] row_t;

  localparam logic [3:0] SEG_DIGIT [DIGIT_LEDS] = '{
    4'd1, 4'd9, 4'd4, 4'd6, 4'd10, 4'd7, 4'd3, 4'd0, 4'd2, 4'd8, 4'd5,
    4'd5, 4'd8, 4'd2, 4'd0, 4'd3, 4'd7, 4'd10, 4'd6, 4'd4, 4'd9, 4'd1
  };

  function automatic row_t digit_pattern(input logic [3:0] d);
    row_t p;
    for (int i = 0; i < DIGIT_LEDS; i++) begin
      p[i] = (SEG_DIGIT[i] == d);
    end
    return p;
  endfunction
endpackage

@@ rtl/core/dmcr_ram.sv @@
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
module dmcr_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/digit_mask_crossfade_renderer.sv @@
// Top level: digit mask crossfade renderer
//
//  channel   signals                                   handshake
//  request   req_type, digit_value, led_index          start & !busy
//  result    red_out, green_out, blue_out, fade_finished  done, one cycle
//  config    wr_index, wr_data                         wr_en
//
// Tick, ignored codes: straight to finish; clear: valid bits cleared first.
// Render: RAM read, weight, blend multiply, brightness multiply. Push: rows
// shift up by read and write-back, new pattern to row 0. Commit: bit-serial
// step divider unless instant or zero fade time. Reset clears the bank valid
// bits at once; no sweep. The result cannot be stalled; busy holds off requests.
`timescale 1ns / 1ps
`include "digit_mask_crossfade_renderer_defines.svh"
module digit_mask_crossfade_renderer #(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  req_type,
  input  logic [3:0]  digit_value,
  input  logic [7:0]  led_index,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        fade_finished,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [23:0] wr_data
);
  localparam int RW = MAX_DIGITS > 1 ? $clog2(MAX_DIGITS) : 1;
  localparam int NW = $clog2(MAX_DIGITS + 1);
  localparam int LW = $clog2(MAX_DIGITS * dmcr_pkg::DIGIT_LEDS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PWR   = 4'd3;
  localparam logic [3:0] S_PZERO = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RW    = 4'd7;
  localparam logic [3:0] S_RM1   = 4'd8;
  localparam logic [3:0] S_RM2   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]  digits_in_use;
  logic        instant_mode;
  logic [15:0] fade_time_ms;
  logic [8:0]  brightness_q8;
  logic [23:0] on_color;
  logic [23:0] off_color;

  logic        write_bank;
  logic [16:0] fader;
  logic [16:0] fade_step;
  logic        fade_done;
  logic [MAX_DIGITS-1:0] vld0, vld1;

  logic [3:0]  state;
  logic [3:0]  digit_q;
  logic [7:0]  led_q;
  logic [RW-1:0] rcnt;
  logic        rv;

  logic [15:0] rem;
  logic [20:0] quot, dvd;
  logic [4:0]  dcnt;

  logic        inr, v0, v1;
  logic [4:0]  col;
  logic [16:0] w;
  logic [23:0] mix [3];

  // clamped digit count and active LED count
  logic [NW-1:0] nd;
  logic [LW-1:0] nleds;
  always_comb begin
    if (digits_in_use == 4'd0) begin
      nd = NW'(1);
    end else if (5'(digits_in_use) > 5'(MAX_DIGITS)) begin
      nd = NW'(MAX_DIGITS);
    end else begin
      nd = NW'(digits_in_use);
    end
    nleds = LW'(nd) * LW'(dmcr_pkg::DIGIT_LEDS);
  end

  // led / 22 by reciprocal, exact for 8-bit indexes
  logic [16:0] rowprod;
  logic [3:0]  led_row;
  logic [8:0]  row_base;
  assign rowprod  = 17'(led_q) * 17'd373;
  assign led_row  = rowprod[16:13];
  assign row_base = 9'(led_row) * 9'd22;

  // RAM ports
  logic [RW-1:0] raddr, waddr;
  logic          we;
  dmcr_pkg::row_t wdata, rd0, rd1;

  always_comb begin
    raddr = (state == S_PRD) ? RW'(rcnt - RW'(1)) : RW'(led_row);
    we    = (state == S_PWR) || (state == S_PZERO);
    waddr = (state == S_PWR) ? rcnt : RW'(0);
    wdata = (state == S_PWR) ? ((write_bank ? rd1 : rd0) & {dmcr_pkg::DIGIT_LEDS{rv}})
                             : dmcr_pkg::digit_pattern(digit_q);
  end

  dmcr_ram #(.WIDTH(dmcr_pkg::DIGIT_LEDS), .DEPTH(MAX_DIGITS)) u_bank0 (
    .clk(clk), .we(we && !write_bank), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd0)
  );
  dmcr_ram #(.WIDTH(dmcr_pkg::DIGIT_LEDS), .DEPTH(MAX_DIGITS)) u_bank1 (
    .clk(clk), .we(we && write_bank), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd1)
  );

  // divider step
  logic [16:0] trial;
  logic        qbit;
  logic [20:0] quot_next;
  assign trial     = {rem, dvd[20]};
  assign qbit      = trial >= {1'b0, fade_time_ms};
  assign quot_next = {quot[19:0], qbit};

  // tick sum
  logic [17:0] tsum;
  assign tsum = (fader < dmcr_pkg::Q_ONE) ? (18'(fader) + 18'(fade_step)) : 18'(fader);

  // render weight
  logic bw, bo;
  assign bw = (write_bank ? rd1[col] : rd0[col]) && (write_bank ? v1 : v0);
  assign bo = (write_bank ? rd0[col] : rd1[col]) && (write_bank ? v0 : v1);

  logic [7:0] on_ch [3];
  logic [7:0] off_ch [3];
  assign on_ch[0]  = on_color[23:16];
  assign on_ch[1]  = on_color[15:8];
  assign on_ch[2]  = on_color[7:0];
  assign off_ch[0] = off_color[23:16];
  assign off_ch[1] = off_color[15:8];
  assign off_ch[2] = off_color[7:0];

  logic [26:0] blend [3];
  logic [32:0] scaled [3];
  logic [7:0]  sat [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend[c] = 27'($signed({1'b0, off_ch[c], 16'd0})
               + $signed(9'({1'b0, on_ch[c]}) - 9'({1'b0, off_ch[c]})) * $signed({1'b0, w}));
      scaled[c] = 33'(mix[c]) * 33'(brightness_q8);
      sat[c] = (scaled[c][32:24] > 9'd255) ? 8'd255 : scaled[c][31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_in_use <= 4'd1;
      instant_mode  <= 1'b0;
      fade_time_ms  <= 16'd250;
      brightness_q8 <= 9'd256;
      on_color      <= 24'hFFFFFF;
      off_color     <= 24'h000000;
    end else if (wr_en) begin
      unique case (wr_index)
        dmcr_pkg::REG_DIGITS:     digits_in_use <= wr_data[3:0];
        dmcr_pkg::REG_INSTANT:    instant_mode  <= wr_data[0];
        dmcr_pkg::REG_FADE_TIME:  fade_time_ms  <= wr_data[15:0];
        dmcr_pkg::REG_BRIGHTNESS: brightness_q8 <= wr_data[8:0];
        dmcr_pkg::REG_ON_COLOR:   on_color      <= wr_data;
        dmcr_pkg::REG_OFF_COLOR:  off_color     <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      write_bank <= 1'b0;
      fader      <= '0;
      fade_step  <= dmcr_pkg::Q_ONE;
      fade_done  <= 1'b0;
      vld0       <= '0;
      vld1       <= '0;
      red_out    <= '0;
      green_out  <= '0;
      blue_out   <= '0;
    end else begin
      done <= (state == S_RM2) || (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            digit_q <= digit_value;
            led_q   <= led_index;
            case (req_type)
              dmcr_pkg::REQ_CLEAR: state <= S_CLR;
              dmcr_pkg::REQ_PUSH: begin
                rcnt  <= RW'(nd - NW'(1));
                state <= (nd > NW'(1)) ? S_PRD : S_PZERO;
              end
              dmcr_pkg::REQ_COMMIT: begin
                write_bank <= ~write_bank;
                fader      <= '0;
                fade_done  <= 1'b0;
                if (instant_mode || fade_time_ms == 16'd0) begin
                  fade_step <= dmcr_pkg::Q_ONE;
                  state     <= S_FIN;
                end else begin
                  rem   <= '0;
                  quot  <= '0;
                  dvd   <= dmcr_pkg::STEP_DIVIDEND;
                  dcnt  <= 5'd20;
                  state <= S_DIV;
                end
              end
              dmcr_pkg::REQ_TICK: begin
                if (tsum >= 18'(dmcr_pkg::Q_ONE)) begin
                  fader     <= dmcr_pkg::Q_ONE;
                  fade_done <= 1'b1;
                end else begin
                  fader <= tsum[16:0];
                end
                state <= S_FIN;
              end
              dmcr_pkg::REQ_RENDER: state <= S_RRD;
              default: state <= S_FIN;
            endcase
          end
        end
        S_CLR: begin
          for (int r = 0; r < MAX_DIGITS; r++) begin
            if (NW'(r) < nd) begin
              if (write_bank) vld1[r] <= 1'b0;
              else vld0[r] <= 1'b0;
            end
          end
          state <= S_FIN;
        end
        S_PRD: begin
          rv    <= write_bank ? vld1[raddr] : vld0[raddr];
          state <= S_PWR;
        end
        S_PWR: begin
          if (write_bank) vld1[rcnt] <= 1'b1;
          else vld0[rcnt] <= 1'b1;
          rcnt  <= rcnt - RW'(1);
          state <= (rcnt == RW'(1)) ? S_PZERO : S_PRD;
        end
        S_PZERO: begin
          if (write_bank) vld1[0] <= 1'b1;
          else vld0[0] <= 1'b1;
          state <= S_FIN;
        end
        S_DIV: begin
          rem  <= qbit ? 16'(trial - {1'b0, fade_time_ms}) : trial[15:0];
          quot <= quot_next;
          dvd  <= {dvd[19:0], 1'b0};
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd0) begin
            fade_step <= (quot_next > 21'(dmcr_pkg::Q_ONE)) ? dmcr_pkg::Q_ONE
                                                            : quot_next[16:0];
            state     <= S_FIN;
          end
        end
        S_RRD: begin
          inr   <= 9'(led_q) < 9'(nleds);
          col   <= 5'(9'(led_q) - row_base);
          v0    <= vld0[raddr];
          v1    <= vld1[raddr];
          state <= S_RW;
        end
        S_RW: begin
          w <= (bw && bo) ? dmcr_pkg::Q_ONE
             : bw ? 17'(dmcr_pkg::Q_ONE - fader)
             : bo ? fader : 17'd0;
          state <= S_RM1;
        end
        S_RM1: begin
          for (int c = 0; c < 3; c++) begin
            mix[c] <= blend[c][23:0];
          end
          state <= S_RM2;
        end
        S_RM2: begin
          red_out   <= inr ? sat[0] : 8'd0;
          green_out <= inr ? sat[1] : 8'd0;
          blue_out  <= inr ? sat[2] : 8'd0;
          state     <= S_IDLE;
        end
        S_FIN: begin
          red_out   <= '0;
          green_out <= '0;
          blue_out  <= '0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy          = state != S_IDLE;
  assign fade_finished = fade_done;

  `DMCR_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `DMCR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not go busy")
  `DMCR_ASSERT_NOW(a_fader_max, 1'b1, fader <= dmcr_pkg::Q_ONE, "fader above one")
  `DMCR_ASSERT_NOW(a_done_full, fade_done, fader == dmcr_pkg::Q_ONE, "fade done, fader short")
endmodule
